### design/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared constants, types and helpers of the page-organized monochrome
// framebuffer drawing block.
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int DISPLAY_WIDTH  = 64;
    localparam int DISPLAY_HEIGHT = 32;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int MAX_SPAN       = (DISPLAY_WIDTH > PAGE_COUNT) ? DISPLAY_WIDTH : PAGE_COUNT;
    localparam int CNT_W          = $clog2(MAX_SPAN + 1);

    typedef enum logic [2:0] {
        CMD_PIXEL = 3'd0,
        CMD_HLINE = 3'd1,
        CMD_VLINE = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] byte_addr(input int page, input int col);
        byte_addr = ADDR_W'(page * DISPLAY_WIDTH + col);
    endfunction

    function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
        span_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    endfunction

    function automatic logic [7:0] apply_color(input logic [7:0] data, input logic [7:0] mask,
                                               input logic [1:0] color);
        case (color)
            COLOR_BLACK:  apply_color = data & ~mask;
            COLOR_WHITE:  apply_color = data | mask;
            COLOR_INVERT: apply_color = data ^ mask;
            default:      apply_color = data;
        endcase
    endfunction

endpackage

### design/mpfd_frame_ram.sv
// ----------------------------------------------------------------------------
// mpfd_frame_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpfd_frame_ram
(
    input  logic                      clk,
    input  mpfd_pkg::mem_req_t        req,
    output logic [7:0]                rd_data
);

    logic [7:0] frame_mem [mpfd_pkg::STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            frame_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= frame_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mono_page_framebuffer_draw.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// Page-organized monochrome framebuffer with pixel, clipped line, clear and
// byte read commands.
//
// A command transfers at a rising edge with start high and busy low. busy
// stays high until the result: done pulses for one cycle with read_data and
// nothing_drawn valid; the receiver cannot hold it off. busy falls the cycle
// after done, so the next command can transfer then.
// A draw command clips its span, then writes one byte per page or column it
// touches; an unused command or an off-screen draw goes straight to done,
// and clear all zeroes every one of the STORE_BYTES (256) bytes.
// A line runs one byte per cycle through the read-modify-write pipeline
// on the frame RAM. Clear all sweeps one byte per cycle through the RAM
// write port. After reset the same sweep zeroes the store with busy high,
// and no done is given for it.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] length,
    input  logic [1:0]         color,
    input  logic [7:0]         byte_index,
    output logic               done,
    output logic [7:0]         read_data,
    output logic               nothing_drawn
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CALC  = 6'b000010,
        ST_RUN   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    localparam int AW = mpfd_pkg::ADDR_W;
    localparam int CW = mpfd_pkg::CNT_W;

    state_t                  state_reg, state_next;
    mpfd_pkg::cmd_t          cmd_reg;
    logic signed [15:0]      x_reg, y_reg, len_reg;
    logic [1:0]              color_reg;
    logic [7:0]              index_reg;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    vert_reg, vert_next;
    logic                    first_reg, first_next;
    logic [2:0]              lo_reg, lo_next, hi_reg, hi_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           pend_addr_reg, pend_addr_next;
    logic [7:0]              pend_mask_reg, pend_mask_next;
    logic                    none_reg, none_next;
    logic                    is_read_reg, is_read_next;
    logic                    clr_cmd_reg, clr_cmd_next;

    logic                    accept;
    logic                    is_vert;
    logic signed [17:0]      a_s, b_s, eff_len_s, sum_s, first_s, stop_s, last_s;
    logic signed [17:0]      lim_a_s, lim_b_s;
    logic                    draw_ok;
    logic [7:0]              mask_cur;
    logic [2:0]              lo_eff, hi_eff;
    logic [7:0]              rd_data;
    mpfd_pkg::mem_req_t      req;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= mpfd_pkg::cmd_t'(command);
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            len_reg   <= length;
            color_reg <= color;
            index_reg <= byte_index;
        end
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        cnt_reg       <= cnt_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            vert_reg    <= 1'b0;
            first_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            none_reg    <= 1'b0;
            is_read_reg <= 1'b0;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            vert_reg    <= vert_next;
            first_reg   <= first_next;
            pend_reg    <= pend_next;
            none_reg    <= none_next;
            is_read_reg <= is_read_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    // clip against the screen
    always_comb
    begin
        is_vert   = (cmd_reg == mpfd_pkg::CMD_VLINE);
        a_s       = is_vert ? 18'(y_reg) : 18'(x_reg);
        b_s       = is_vert ? 18'(x_reg) : 18'(y_reg);
        lim_a_s   = is_vert ? 18'(mpfd_pkg::DISPLAY_HEIGHT) : 18'(mpfd_pkg::DISPLAY_WIDTH);
        lim_b_s   = is_vert ? 18'(mpfd_pkg::DISPLAY_WIDTH) : 18'(mpfd_pkg::DISPLAY_HEIGHT);
        eff_len_s = (cmd_reg == mpfd_pkg::CMD_PIXEL) ? 18'sd1 : 18'(len_reg);
        sum_s     = a_s + eff_len_s;
        first_s   = (a_s < 18'sd0) ? 18'sd0 : a_s;
        stop_s    = (sum_s > lim_a_s) ? lim_a_s : sum_s;
        last_s    = stop_s - 18'sd1;
        draw_ok   = (b_s >= 18'sd0) && (b_s < lim_b_s) && (stop_s > first_s);
    end

    always_comb
    begin
        lo_eff   = (first_reg || !vert_reg) ? lo_reg : 3'd0;
        hi_eff   = ((cnt_reg == CW'(1)) || !vert_reg) ? hi_reg : 3'd7;
        mask_cur = mpfd_pkg::span_mask(lo_eff, hi_eff);
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        vert_next      = vert_reg;
        first_next     = first_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_mask_next = pend_mask_reg;
        none_next      = none_reg;
        is_read_next   = is_read_reg;
        clr_cmd_next   = clr_cmd_reg;
        req            = '0;
        req.wr_en      = pend_reg;
        req.wr_addr    = pend_addr_reg;
        req.wr_data    = mpfd_pkg::apply_color(rd_data, pend_mask_reg, color_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_CALC;
                    none_next    = 1'b0;
                    is_read_next = 1'b0;
                end
            end
            ST_CALC:
            begin
                unique case (cmd_reg) inside
                    mpfd_pkg::CMD_PIXEL, mpfd_pkg::CMD_HLINE, mpfd_pkg::CMD_VLINE:
                    begin
                        first_next = 1'b1;
                        vert_next  = is_vert;
                        if (!draw_ok)
                        begin
                            none_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_RUN;
                            if (is_vert)
                            begin
                                addr_next = mpfd_pkg::byte_addr(int'(first_s >>> 3), int'(b_s));
                                cnt_next  = CW'((last_s >>> 3) - (first_s >>> 3) + 18'sd1);
                                lo_next   = first_s[2:0];
                                hi_next   = last_s[2:0];
                            end
                            else
                            begin
                                addr_next = mpfd_pkg::byte_addr(int'(b_s >>> 3), int'(first_s));
                                cnt_next  = CW'(stop_s - first_s);
                                lo_next   = b_s[2:0];
                                hi_next   = b_s[2:0];
                            end
                        end
                    end
                    mpfd_pkg::CMD_CLEAR:
                    begin
                        addr_next    = '0;
                        clr_cmd_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    mpfd_pkg::CMD_READ:
                    begin
                        if (32'(index_reg) < mpfd_pkg::STORE_BYTES)
                        begin
                            is_read_next = 1'b1;
                            state_next   = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RUN:
            begin
                req.rd_en      = 1'b1;
                req.rd_addr    = addr_reg;
                pend_next      = 1'b1;
                pend_addr_next = addr_reg;
                pend_mask_next = mask_cur;
                first_next     = 1'b0;
                cnt_next       = cnt_reg - CW'(1);
                addr_next      = addr_reg + (vert_reg ? AW'(mpfd_pkg::DISPLAY_WIDTH) : AW'(1));
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = AW'(index_reg);
                state_next  = ST_DONE;
            end
            ST_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = addr_reg;
                req.wr_data = 8'h00;
                addr_next   = addr_reg + AW'(1);
                if (32'(addr_reg) == mpfd_pkg::STORE_BYTES - 1)
                begin
                    addr_next    = '0;
                    clr_cmd_next = 1'b0;
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mpfd_frame_ram u_frame_ram
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign done          = (state_reg == ST_DONE);
    assign read_data     = is_read_reg ? rd_data : 8'h00;
    assign nothing_drawn = none_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("transfer did not raise busy");

    a_no_pend_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pend_reg)
        else $error("pending write collides with clear sweep");

    a_pend_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_RUN))
        else $error("pending write without a read");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg != '0))
        else $error("line run with zero count");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a command in progress");

endmodule

### tb/mono_page_framebuffer_draw_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_tb
// Self-checking bench for the page-organized monochrome framebuffer. A
// behavioral copy of the frame store predicts every result; directed
// corner cases (clipping, partial page masks, color and command extremes)
// are followed by three random phases with varying sender gaps.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_tb;

    localparam logic [1:0] COLOR_NONE      = 2'd3;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         PHASE_ITEMS     = 230;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nothing_drawn;
    } draw_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] length;
    logic [1:0]         color;
    logic [7:0]         byte_index;
    logic               done;
    logic [7:0]         read_data;
    logic               nothing_drawn;

    logic [7:0]   frame_model [mpfd_pkg::STORE_BYTES];
    draw_result_t pending_results [$];
    int           error_count;
    int           item_count;
    int           read_count;
    int           draw_count;
    int           clipped_count;
    int           clear_count;
    int           sender_idle_pct;
    int           quiet_cycles;

    mono_page_framebuffer_draw u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .length        (length),
        .color         (color),
        .byte_index    (byte_index),
        .done          (done),
        .read_data     (read_data),
        .nothing_drawn (nothing_drawn)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void paint_byte(int addr, logic [7:0] mask, logic [1:0] c);
        if (addr < 0 || addr >= mpfd_pkg::STORE_BYTES)
            return;
        case (c)
            mpfd_pkg::COLOR_BLACK:  frame_model[addr] = frame_model[addr] & ~mask;
            mpfd_pkg::COLOR_WHITE:  frame_model[addr] = frame_model[addr] | mask;
            mpfd_pkg::COLOR_INVERT: frame_model[addr] = frame_model[addr] ^ mask;
            default:                ;
        endcase
    endfunction

    function automatic bit model_pixel(int x, int y, logic [1:0] c);
        if (x < 0 || x >= mpfd_pkg::DISPLAY_WIDTH || y < 0 || y >= mpfd_pkg::DISPLAY_HEIGHT)
            return 1'b1;
        paint_byte((y / 8) * mpfd_pkg::DISPLAY_WIDTH + x, 8'(1 << (y % 8)), c);
        return 1'b0;
    endfunction

    function automatic bit model_hline(int x, int y, int w, logic [1:0] c);
        int i;
        if (y < 0 || y >= mpfd_pkg::DISPLAY_HEIGHT)
            return 1'b1;
        if (x < 0)
        begin
            w = w + x;
            x = 0;
        end
        if (x + w > mpfd_pkg::DISPLAY_WIDTH)
            w = mpfd_pkg::DISPLAY_WIDTH - x;
        if (w <= 0)
            return 1'b1;
        for (i = 0; i < w; i++)
            paint_byte((y / 8) * mpfd_pkg::DISPLAY_WIDTH + x + i, 8'(1 << (y % 8)), c);
        return 1'b0;
    endfunction

    function automatic bit model_vline(int x, int y, int h, logic [1:0] c);
        int last;
        int page;
        int top;
        int lo;
        int hi;
        if (x < 0 || x >= mpfd_pkg::DISPLAY_WIDTH)
            return 1'b1;
        if (y < 0)
        begin
            h = h + y;
            y = 0;
        end
        if (y + h > mpfd_pkg::DISPLAY_HEIGHT)
            h = mpfd_pkg::DISPLAY_HEIGHT - y;
        if (h <= 0)
            return 1'b1;
        last = y + h - 1;
        for (page = y / 8; page <= last / 8; page++)
        begin
            top = page * 8;
            lo  = (y > top) ? y - top : 0;
            hi  = (last < top + 7) ? last - top : 7;
            paint_byte(page * mpfd_pkg::DISPLAY_WIDTH + x,
                       8'((32'hFF << lo) & (32'hFF >> (7 - hi))), c);
        end
        return 1'b0;
    endfunction

    function automatic draw_result_t model_command(logic [2:0] cmd, logic signed [15:0] px,
                                                   logic signed [15:0] py,
                                                   logic signed [15:0] len,
                                                   logic [1:0] c, logic [7:0] idx);
        draw_result_t r;
        int x;
        int y;
        int w;
        r.read_data     = '0;
        r.nothing_drawn = 1'b0;
        x = px;
        y = py;
        w = len;
        case (cmd)
            mpfd_pkg::CMD_PIXEL: r.nothing_drawn = model_pixel(x, y, c);
            mpfd_pkg::CMD_HLINE: r.nothing_drawn = model_hline(x, y, w, c);
            mpfd_pkg::CMD_VLINE: r.nothing_drawn = model_vline(x, y, w, c);
            mpfd_pkg::CMD_CLEAR: foreach (frame_model[i]) frame_model[i] = '0;
            mpfd_pkg::CMD_READ:
                if (int'(idx) < mpfd_pkg::STORE_BYTES) r.read_data = frame_model[idx];
            default:             ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Call right after a rising edge; returns at the edge that takes the transfer.
    task automatic send_cmd(logic [2:0] cmd, logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] len, logic [1:0] c, logic [7:0] idx);
        draw_result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        pos_x      <= px;
        pos_y      <= py;
        length     <= len;
        color      <= c;
        byte_index <= idx;
        do @(posedge clk); while (busy);
        r = model_command(cmd, px, py, len, c, idx);
        pending_results.push_back(r);
        item_count++;
        if (cmd == mpfd_pkg::CMD_READ)
            read_count++;
        else if (cmd == mpfd_pkg::CMD_CLEAR)
            clear_count++;
        else if (cmd == mpfd_pkg::CMD_PIXEL || cmd == mpfd_pkg::CMD_HLINE
                 || cmd == mpfd_pkg::CMD_VLINE)
        begin
            draw_count++;
            if (r.nothing_drawn)
                clipped_count++;
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic test_pixel_corners();
        send_cmd(mpfd_pkg::CMD_PIXEL, 0, 0, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_PIXEL, mpfd_pkg::DISPLAY_WIDTH - 1,
                 mpfd_pkg::DISPLAY_HEIGHT - 1, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK, 0);
        send_cmd(mpfd_pkg::CMD_READ, -1, -1, -1, COLOR_NONE, 255);
        send_cmd(mpfd_pkg::CMD_PIXEL, -1, 0, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_PIXEL, mpfd_pkg::DISPLAY_WIDTH,
                 mpfd_pkg::DISPLAY_HEIGHT - 1, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_PIXEL, 0, mpfd_pkg::DISPLAY_HEIGHT, 0,
                 mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_PIXEL, -32768, 32767, 32767, mpfd_pkg::COLOR_INVERT, 255);
        send_cmd(mpfd_pkg::CMD_PIXEL, 5, 10, 0, COLOR_NONE, 0);
    endtask

    task automatic test_hline_clipping();
        send_cmd(mpfd_pkg::CMD_HLINE, -32768, 5, 32767, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, 60, 9, 32767, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, -10, 5, 20, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, 10, 6, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, 10, 6, -32768, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, 0, 7, mpfd_pkg::DISPLAY_WIDTH,
                 mpfd_pkg::COLOR_INVERT, 0);
        send_cmd(mpfd_pkg::CMD_HLINE, 0, -1, mpfd_pkg::DISPLAY_WIDTH,
                 mpfd_pkg::COLOR_WHITE, 0);
    endtask

    task automatic test_vline_masks();
        send_cmd(mpfd_pkg::CMD_VLINE, 5, 3, 20, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_VLINE, 6, -5, 10, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_VLINE, 7, 0, 32767, mpfd_pkg::COLOR_INVERT, 0);
        send_cmd(mpfd_pkg::CMD_VLINE, mpfd_pkg::DISPLAY_WIDTH, 0, 5, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_VLINE, 8, mpfd_pkg::DISPLAY_HEIGHT - 1, 1,
                 mpfd_pkg::COLOR_BLACK, 0);
        send_cmd(mpfd_pkg::CMD_VLINE, 40, 40, 5, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK, 5);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK,
                 mpfd_pkg::DISPLAY_WIDTH + 5);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK,
                 2 * mpfd_pkg::DISPLAY_WIDTH + 5);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK,
                 mpfd_pkg::DISPLAY_WIDTH + 7);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK,
                 mpfd_pkg::DISPLAY_WIDTH + 60);
    endtask

    task automatic test_clear_and_spare();
        send_cmd(CMD_SPARE_FIRST, 3, 3, 3, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(CMD_SPARE_LAST, 0, 0, 8, mpfd_pkg::COLOR_INVERT, 5);
        send_cmd(mpfd_pkg::CMD_CLEAR, 0, 0, 0, mpfd_pkg::COLOR_WHITE, 0);
        send_cmd(mpfd_pkg::CMD_READ, 0, 0, 0, mpfd_pkg::COLOR_BLACK, 255);
        wait_for_results();
    endtask

    task automatic send_random_item();
        logic [2:0]         cmd;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] len;
        logic [1:0]         c;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 35)
            cmd = mpfd_pkg::CMD_READ;
        else if (pick < 55)
            cmd = mpfd_pkg::CMD_PIXEL;
        else if (pick < 72)
            cmd = mpfd_pkg::CMD_HLINE;
        else if (pick < 89)
            cmd = mpfd_pkg::CMD_VLINE;
        else if (pick < 91)
            cmd = mpfd_pkg::CMD_CLEAR;
        else if (pick < 95)
            cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        else
            cmd = 3'($urandom_range(7));
        if ($urandom_range(9) == 0)
        begin
            px  = 16'($urandom);
            py  = 16'($urandom);
            len = 16'($urandom);
        end
        else
        begin
            px  = 16'($urandom_range(mpfd_pkg::DISPLAY_WIDTH + 15) - 8);
            py  = 16'($urandom_range(mpfd_pkg::DISPLAY_HEIGHT + 15) - 8);
            len = 16'($urandom_range(mpfd_pkg::DISPLAY_WIDTH + 15) - 8);
        end
        c = ($urandom_range(9) == 0) ? COLOR_NONE : 2'($urandom_range(2));
        send_cmd(cmd, px, py, len, c, 8'($urandom));
    endtask

    task automatic test_random_traffic(int count, int idle_pct);
        int n;
        sender_idle_pct = idle_pct;
        for (n = 0; n < count; n++)
        begin
            send_random_item();
            if (n % 75 == 74)
                wait_for_results();
        end
    endtask

    always @(posedge clk)
    begin : check_results
        draw_result_t want;
        if (done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", read_data, 0);
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (nothing_drawn !== want.nothing_drawn)
                    report_mismatch("nothing_drawn", nothing_drawn, want.nothing_drawn);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        error_count     = 0;
        item_count      = 0;
        read_count      = 0;
        draw_count      = 0;
        clipped_count   = 0;
        clear_count     = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 0;
        foreach (frame_model[i]) frame_model[i] = '0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= mpfd_pkg::CMD_READ;
        pos_x      <= '0;
        pos_y      <= '0;
        length     <= '0;
        color      <= mpfd_pkg::COLOR_BLACK;
        byte_index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_corners();
        test_hline_clipping();
        test_vline_masks();
        test_clear_and_spare();
        test_random_traffic(PHASE_ITEMS, 16);
        test_random_traffic(PHASE_ITEMS, 68);
        test_random_traffic(PHASE_ITEMS, 0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d reads, %0d clears, %0d pixel and line draws",
                 item_count, read_count, clear_count, draw_count);
        $display("of which %0d were clipped away; sender gaps 16%%, 68%% and none",
                 clipped_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
